>>> sv/dlmv_pkg.sv
// shared constants, codes and types of the dense layer matrix-vector unit
// no dependencies; imported by every module of the block
package dlmv_pkg;

   // sizes of the stores
   localparam int MAX_INPUTS  = 256;
   localparam int MAX_OUTPUTS = 64;
   localparam int ROW_W       = $clog2(MAX_INPUTS);
   localparam int COL_W       = $clog2(MAX_OUTPUTS);
   localparam int WADDR_W     = ROW_W + COL_W;
   localparam int DATA_W      = 16;
   localparam int FRAC_W      = 8;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int ACC_W       = PROD_W + ROW_W + 1;
   localparam int ILEN_W      = 9;
   localparam int OLEN_W      = 7;
   localparam int CSR_W       = 9;

   // item kinds on the request side
   localparam logic [1:0] KIND_WEIGHT = 2'd0;
   localparam logic [1:0] KIND_BIAS   = 2'd1;
   localparam logic [1:0] KIND_INPUT  = 2'd2;

   // register indexes
   localparam logic CSR_INPUT_LENGTH  = 1'b0;
   localparam logic CSR_OUTPUT_LENGTH = 1'b1;

   // memory write request
   typedef struct packed {
      logic              we_weight;
      logic              we_bias;
      logic              we_input;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DATA_W-1:0] value;
   } mem_wr_type;

   // memory read request for one multiply-accumulate step
   typedef struct packed {
      logic             en;
      logic             bias_en;
      logic             first;
      logic             last;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } mem_rd_type;

   // step control that travels beside the operands
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

   // finished column result
   typedef struct packed {
      logic                     valid;
      logic                     sat;
      logic signed [DATA_W-1:0] value;
   } mac_res_type;

endpackage

>>> sv/dense_layer_matvec_bias_unit.sv
// Fully connected layer in signed Q8.8: weight words (tuser 0), bias words (tuser 1) and
// input words (tuser 2) are stored as they are accepted, and the input word with tlast
// set starts a run that emits one result word per output column, in column order, the
// last one with tlast. Within a column the single multiply-accumulate unit reads one
// weight and one input element per cycle from the weight memory and input store, and
// the pipeline then drains before the column result is put out. The request side is
// not ready during a run; the last result may still wait on the response side while
// new words are taken. Memories are not cleared at reset; every entry a run reads must
// be written first.
// depends on dlmv_pkg, dlmv_mem_bank and dlmv_mac
module dense_layer_matvec_bias_unit import dlmv_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,  // row_index[7:0], column_index[13:8], value[29:14]
   input  logic [1:0]        req_tuser,  // kind[1:0]
   input  logic              req_tlast,  // final_element
   // response side
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,  // output_index[5:0], output_value[21:6]
   output logic              rsp_tuser,  // saturated
   output logic              rsp_tlast,  // last_result
   // configuration
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_PUT   = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [COL_W-1:0]         col_ff, col_in;
   logic [ILEN_W-1:0]        ilen_ff;
   logic [OLEN_W-1:0]        olen_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]         rsp_idx_ff;
   logic [DATA_W-1:0]        rsp_val_ff;
   logic                     rsp_sat_ff;
   logic                     rsp_last_ff;
   logic                     req_acc;
   logic                     row_end;
   logic                     col_end;
   logic                     out_free;
   logic [ROW_W-1:0]         req_row;
   logic [COL_W-1:0]         req_col;
   logic [DATA_W-1:0]        req_val;
   mem_wr_type               wr;
   mem_rd_type               rd;
   logic signed [DATA_W-1:0] weight_q, input_q, bias_q;
   mac_ctl_type              ctl_q;
   mac_res_type              res;

   assign req_row = req_tdata[ROW_W-1:0];
   assign req_col = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_val = req_tdata[ROW_W+COL_W+DATA_W-1:ROW_W+COL_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign row_end    = ({1'b0, row_ff} == ilen_ff - ILEN_W'(1));
   assign col_end    = ({1'b0, col_ff} + OLEN_W'(1) == olen_ff);
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // configuration registers, clamped into their legal range
   always_ff @(posedge clock) begin
      if (reset) begin
         ilen_ff <= ILEN_W'(MAX_INPUTS);
         olen_ff <= OLEN_W'(MAX_OUTPUTS);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INPUT_LENGTH: begin
               if (csr_wdata[ILEN_W-1:0] == '0) begin
                  ilen_ff <= ILEN_W'(1);
               end else if (csr_wdata[ILEN_W-1:0] > ILEN_W'(MAX_INPUTS)) begin
                  ilen_ff <= ILEN_W'(MAX_INPUTS);
               end else begin
                  ilen_ff <= csr_wdata[ILEN_W-1:0];
               end
            end
            CSR_OUTPUT_LENGTH: begin
               if (csr_wdata[OLEN_W-1:0] == '0) begin
                  olen_ff <= OLEN_W'(1);
               end else if (csr_wdata[OLEN_W-1:0] > OLEN_W'(MAX_OUTPUTS)) begin
                  olen_ff <= OLEN_W'(MAX_OUTPUTS);
               end else begin
                  olen_ff <= csr_wdata[OLEN_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // store writes from accepted load and input words
   always_comb begin
      wr.we_weight = req_acc & (req_tuser == KIND_WEIGHT);
      wr.we_bias   = req_acc & (req_tuser == KIND_BIAS);
      wr.we_input  = req_acc & (req_tuser == KIND_INPUT);
      wr.row       = req_row;
      wr.col       = req_col;
      wr.value     = req_val;
   end

   // one read per cycle while a column runs
   always_comb begin
      rd.en      = (state_ff == ST_RUN);
      rd.bias_en = (state_ff == ST_RUN) & (row_ff == '0);
      rd.first   = (row_ff == '0);
      rd.last    = row_end;
      rd.row     = row_ff;
      rd.col     = col_ff;
   end

   // run sequencer: rows inside columns, one result per column
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc & (req_tuser == KIND_INPUT) & req_tlast) begin
               state_in = ST_RUN;
               row_in   = '0;
               col_in   = '0;
            end
         end
         ST_RUN: begin
            if (row_end) begin
               state_in = ST_DRAIN;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         ST_DRAIN: begin
            if (res.valid) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               row_in       = '0;
               if (col_end) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_RUN;
                  col_in   = col_ff + COL_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if ((state_ff == ST_PUT) & out_free) begin
         rsp_idx_ff  <= col_ff;
         rsp_val_ff  <= res.value;
         rsp_sat_ff  <= res.sat;
         rsp_last_ff <= col_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_val_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_sat_ff;
   assign rsp_tlast  = rsp_last_ff;

   dlmv_mem_bank u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .rd       (rd),
      .weight_q (weight_q),
      .input_q  (input_q),
      .bias_q   (bias_q),
      .ctl_q    (ctl_q)
   );

   dlmv_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .weight_q (weight_q),
      .input_q  (input_q),
      .bias_q   (bias_q),
      .ctl_q    (ctl_q),
      .res      (res)
   );

   // a column result only appears while the sequencer waits for it
   a_res_in_drain: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (state_ff == ST_DRAIN))
      else $error("column result outside drain");

   // a waiting response word is never overwritten
   a_put_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PUT) && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_PUT))
      else $error("response overwritten");

   // row counter stays inside the configured length
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> ({1'b0, row_ff} < ilen_ff))
      else $error("row beyond input length");

endmodule

>>> sv/dlmv_mem_bank.sv
// weight memory, bias store and input vector store with registered reads
// depends on dlmv_pkg
module dlmv_mem_bank import dlmv_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mem_wr_type               wr,
   input  mem_rd_type               rd,
   output logic signed [DATA_W-1:0] weight_q,
   output logic signed [DATA_W-1:0] input_q,
   output logic signed [DATA_W-1:0] bias_q,
   output mac_ctl_type              ctl_q
);

   logic [DATA_W-1:0] weight_mem_ff [MAX_INPUTS*MAX_OUTPUTS];
   logic [DATA_W-1:0] bias_mem_ff [MAX_OUTPUTS];
   logic [DATA_W-1:0] input_mem_ff [MAX_INPUTS];
   logic [DATA_W-1:0] weight_q_ff;
   logic [DATA_W-1:0] input_q_ff;
   logic [DATA_W-1:0] bias_q_ff;
   mac_ctl_type       ctl_ff;

   // weight memory, row-major with one row per input element
   always_ff @(posedge clock) begin
      if (wr.we_weight) begin
         weight_mem_ff[{wr.row, wr.col}] <= wr.value;
      end
      if (rd.en) begin
         weight_q_ff <= weight_mem_ff[{rd.row, rd.col}];
      end
   end

   // input vector store
   always_ff @(posedge clock) begin
      if (wr.we_input) begin
         input_mem_ff[wr.row] <= wr.value;
      end
      if (rd.en) begin
         input_q_ff <= input_mem_ff[rd.row];
      end
   end

   // bias store, read once at the start of a column and held
   always_ff @(posedge clock) begin
      if (wr.we_bias) begin
         bias_mem_ff[wr.col] <= wr.value;
      end
      if (rd.bias_en) begin
         bias_q_ff <= bias_mem_ff[rd.col];
      end
   end

   // step control follows the read latency
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff.valid <= rd.en;
         ctl_ff.first <= rd.first;
         ctl_ff.last  <= rd.last;
      end
   end

   assign weight_q = $signed(weight_q_ff);
   assign input_q  = $signed(input_q_ff);
   assign bias_q   = $signed(bias_q_ff);
   assign ctl_q    = ctl_ff;

endmodule

>>> sv/dlmv_mac.sv
// multiply-accumulate unit with bias add, rounding and saturation to Q8.8
// depends on dlmv_pkg
module dlmv_mac import dlmv_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [DATA_W-1:0] weight_q,
   input  logic signed [DATA_W-1:0] input_q,
   input  logic signed [DATA_W-1:0] bias_q,
   input  mac_ctl_type              ctl_q,
   output mac_res_type              res
);

   localparam int TOT_W = ACC_W + 1;
   localparam int Q_W   = TOT_W - FRAC_W;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

   logic signed [PROD_W-1:0] prod_ff;
   mac_ctl_type              pctl_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     fin_ff;
   logic signed [TOT_W-1:0]  tot;
   logic signed [Q_W-1:0]    q;
   logic                     res_valid_ff;
   logic                     res_sat_ff;
   logic signed [DATA_W-1:0] res_value_ff;

   // product stage
   always_ff @(posedge clock) begin
      prod_ff <= weight_q * input_q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pctl_ff <= '0;
      end else begin
         pctl_ff <= ctl_q;
      end
   end

   // accumulate, restarting on the first row of a column
   always_comb begin
      if (pctl_ff.first) begin
         acc_in = ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (pctl_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff <= 1'b0;
      end else begin
         fin_ff <= pctl_ff.valid & pctl_ff.last;
      end
   end

   // bias in Q16.16, round half up, drop the low 8 fraction bits
   assign tot = TOT_W'(acc_ff)
              + {{(TOT_W-DATA_W-FRAC_W){bias_q[DATA_W-1]}}, bias_q, {FRAC_W{1'b0}}}
              + TOT_W'(1 << (FRAC_W - 1));
   assign q   = tot[TOT_W-1:FRAC_W];

   // saturate into the result register
   always_ff @(posedge clock) begin
      if (fin_ff) begin
         if (q > Q_MAX) begin
            res_value_ff <= Q_MAX[DATA_W-1:0];
            res_sat_ff   <= 1'b1;
         end else if (q < Q_MIN) begin
            res_value_ff <= Q_MIN[DATA_W-1:0];
            res_sat_ff   <= 1'b1;
         end else begin
            res_value_ff <= q[DATA_W-1:0];
            res_sat_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= fin_ff;
      end
   end

   assign res.valid = res_valid_ff;
   assign res.sat   = res_sat_ff;
   assign res.value = res_value_ff;

endmodule

>>> bench/dense_layer_matvec_bias_unit_test.sv
// self-checking bench for dense_layer_matvec_bias_unit: directed and random word streams,
// a cycle-free predictor of the layer and a field-wise check of every result word
// depends on dlmv_pkg and the dense_layer_matvec_bias_unit rtl
module dense_layer_matvec_bias_unit_test import dlmv_pkg::*;;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 30;
   localparam int STALL_LIMIT   = 3000;
   localparam int LONG_HOLD     = 400;
   localparam int RANDOM_WORDS  = 80;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [DATA_W-1:0] value;
      logic              fin;
   } req_word_type;

   typedef struct packed {
      logic [COL_W-1:0]  index;
      logic [DATA_W-1:0] value;
      logic              sat;
      logic              last;
   } column_result_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;  // row_index[7:0], column_index[13:8], value[29:14]
   logic [1:0]        req_tuser  = '0;  // kind[1:0]
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;        // output_index[5:0], output_value[21:6]
   logic              rsp_tuser;        // saturated
   logic              rsp_tlast;
   logic              csr_we     = 1'b0;
   logic              csr_index  = 1'b0;
   logic [CSR_W-1:0]  csr_wdata  = '0;

   // predictor state: stores and layer sizes
   logic signed [DATA_W-1:0] weight_mem [0:MAX_INPUTS*MAX_OUTPUTS-1];
   logic signed [DATA_W-1:0] bias_mem   [0:MAX_OUTPUTS-1];
   logic signed [DATA_W-1:0] input_mem  [0:MAX_INPUTS-1];
   int in_len  = MAX_INPUTS;
   int out_len = MAX_OUTPUTS;

   // entries the stimulus has already written
   bit weight_known [0:MAX_INPUTS*MAX_OUTPUTS-1];
   bit bias_known   [0:MAX_OUTPUTS-1];
   bit input_known  [0:MAX_INPUTS-1];

   req_word_type      pending_words[$];
   column_result_type expected_columns[$];

   int queued_words   = 0;
   int accepted_words = 0;
   int real_words     = 0;
   int fail_count     = 0;
   int stall_cycles   = 0;
   int send_gap       = 0;
   int hold_left      = 0;
   bit quiet          = 1'b0;
   bit long_hold_armed = 1'b0;
   bit long_hold_done  = 1'b0;
   bit req_fire       = 1'b0;
   bit rsp_fire       = 1'b0;

   dense_layer_matvec_bias_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // layer model: store the word, and on the final input element compute every column
   task automatic apply_word(req_word_type w);
      longint acc;
      longint rounded;
      column_result_type res;
      case (w.kind)
         KIND_WEIGHT: weight_mem[{w.row, w.col}] = w.value;
         KIND_BIAS:   bias_mem[w.col] = w.value;
         KIND_INPUT: begin
            input_mem[w.row] = w.value;
            if (w.fin) begin
               for (int c = 0; c < out_len; c++) begin
                  acc = longint'(bias_mem[c]) * 256;
                  for (int r = 0; r < in_len; r++)
                     acc += longint'(weight_mem[r * MAX_OUTPUTS + c]) * longint'(input_mem[r]);
                  // round half up, then clip to 16 bits
                  rounded = (acc + 128) >>> FRAC_W;
                  res.sat = 1'b0;
                  if (rounded > 32767) begin
                     rounded = 32767;
                     res.sat = 1'b1;
                  end else if (rounded < -32768) begin
                     rounded = -32768;
                     res.sat = 1'b1;
                  end
                  res.index = c[COL_W-1:0];
                  res.value = rounded[DATA_W-1:0];
                  res.last  = (c == out_len - 1);
                  expected_columns = {expected_columns, res};
               end
            end
         end
         default: ;
      endcase
   endtask

   // sample both channels, predict and check
   always @(posedge clock) begin
      column_result_type got;
      column_result_type want;
      bit stray;
      stray = 1'b0;
      req_fire = req_tvalid && req_tready && !reset;
      rsp_fire = rsp_tvalid && rsp_tready && !reset;
      if (req_fire) begin
         accepted_words++;
         apply_word({req_tuser, req_tdata[7:0], req_tdata[13:8], req_tdata[29:14], req_tlast});
      end
      if (rsp_fire) begin
         got = {rsp_tdata[5:0], rsp_tdata[21:6], rsp_tuser, rsp_tlast};
         if (expected_columns.size() == 0) begin
            stray = 1'b1;
            fail_count++;
            if (fail_count <= 40)
               $display("%0t: unexpected result word, got index %0d value %h sat %b last %b",
                        $time, got.index, got.value, got.sat, got.last);
         end else begin
            want = expected_columns.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 40)
                  $display("%0t: expected %0d %h %b %b, got %0d %h %b %b",
                           $time, want.index, want.value, want.sat, want.last,
                           got.index, got.value, got.sat, got.last);
            end
         end
      end
      // watchdog on cycles with no transfer at all; stray result words are no progress
      if (req_fire || (rsp_fire && !stray) || csr_we)
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("dense_layer_matvec_bias_unit_test NOT OK");
         $finish;
      end
   end

   // request driver: offers queued words, with random gaps while not quiet
   always @(negedge clock) begin
      req_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fire) begin
         // word still on offer
      end else if (send_gap > 0) begin
         send_gap--;
         req_tvalid <= 1'b0;
      end else if (pending_words.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
         send_gap = $urandom_range(0, 2);
         req_tvalid <= 1'b0;
      end else if (pending_words.size() != 0) begin
         w = pending_words.pop_front();
         req_tvalid <= 1'b1;
         req_tdata  <= {2'b00, w.value, w.col, w.row};
         req_tuser  <= w.kind;
         req_tlast  <= w.fin;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // response side: short random stalls while not quiet, plus one long hold while a run is busy
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_armed && !long_hold_done && rsp_tvalid) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         hold_left = $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // register write while idle; the model takes the clamped size
   task automatic write_reg(logic idx, logic [CSR_W-1:0] val);
      int v;
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INPUT_LENGTH) begin
         v = int'(val);
         in_len = (v < 1) ? 1 : (v > MAX_INPUTS) ? MAX_INPUTS : v;
      end else begin
         v = int'(val & 9'h07F);
         out_len = (v < 1) ? 1 : (v > MAX_OUTPUTS) ? MAX_OUTPUTS : v;
      end
   endtask

   task automatic queue_word(logic [1:0] kind, int row, int col, logic [DATA_W-1:0] value,
                             logic fin);
      req_word_type w;
      w.kind  = kind;
      w.row   = row[ROW_W-1:0];
      w.col   = col[COL_W-1:0];
      w.value = value;
      w.fin   = fin;
      pending_words = {pending_words, w};
      queued_words++;
      if (kind != KIND_UNUSED)
         real_words++;
      case (kind)
         KIND_WEIGHT: weight_known[{w.row, w.col}] = 1'b1;
         KIND_BIAS:   bias_known[w.col] = 1'b1;
         KIND_INPUT:  input_known[w.row] = 1'b1;
         default: ;
      endcase
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3: return DATA_W'($urandom);
         default: return DATA_W'($urandom_range(0, 1024) - 512);
      endcase
   endfunction

   // write every entry of the active window that a run would read and that is still unset
   task automatic fill_unwritten();
      for (int r = 0; r < in_len; r++)
         if (!input_known[r])
            queue_word(KIND_INPUT, r, $urandom_range(0, 63), pick_value(), 1'b0);
      for (int c = 0; c < out_len; c++)
         if (!bias_known[c])
            queue_word(KIND_BIAS, $urandom_range(0, 255), c, pick_value(), 1'b0);
      for (int r = 0; r < in_len; r++)
         for (int c = 0; c < out_len; c++)
            if (!weight_known[r * MAX_OUTPUTS + c])
               queue_word(KIND_WEIGHT, r, c, pick_value(), 1'b0);
   endtask

   // one frame: some noise, fresh loads, the input vector, then the starting word
   task automatic random_frame();
      int first_row;
      int keep;
      int last_row;
      repeat ($urandom_range(0, 2)) begin
         case ($urandom_range(0, 2))
            0: queue_word(KIND_UNUSED, $urandom_range(0, 255), $urandom_range(0, 63),
                          DATA_W'($urandom), 1'($urandom_range(0, 1)));
            1: queue_word(KIND_WEIGHT, $urandom_range(0, 255), $urandom_range(0, 63),
                          pick_value(), 1'($urandom_range(0, 1)));
            default: queue_word(KIND_BIAS, $urandom_range(0, 255), $urandom_range(0, 63),
                                pick_value(), 1'($urandom_range(0, 1)));
         endcase
      end
      repeat ($urandom_range(0, in_len))
         queue_word(KIND_WEIGHT, $urandom_range(0, in_len - 1), $urandom_range(0, out_len - 1),
                    pick_value(), 1'b0);
      repeat ($urandom_range(0, 2))
         queue_word(KIND_BIAS, $urandom_range(0, 255), $urandom_range(0, out_len - 1),
                    pick_value(), 1'b0);
      // now and then only part of the vector is refreshed and stale entries are reused
      first_row = $urandom_range(0, in_len - 1);
      keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, in_len) : in_len;
      for (int k = 0; k < keep; k++)
         queue_word(KIND_INPUT, (first_row + k) % in_len, $urandom_range(0, 63), pick_value(),
                    1'b0);
      fill_unwritten();
      last_row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, in_len - 1);
      queue_word(KIND_INPUT, last_row, $urandom_range(0, 63), pick_value(), 1'b1);
   endtask

   // wait until every word is taken and every result is back, then let the block settle
   task automatic drain();
      do
         @(negedge clock);
      while (accepted_words != queued_words || expected_columns.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int base;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed: smallest sizes, reached by clamping a zero and a masked write
      write_reg(CSR_INPUT_LENGTH, 9'd0);
      write_reg(CSR_OUTPUT_LENGTH, 9'h080);
      // unknown kind is dropped, final flag on loads is ignored
      queue_word(KIND_UNUSED, 255, 63, 16'hFFFF, 1'b1);
      queue_word(KIND_WEIGHT, 0, 0, 16'h8000, 1'b0);
      queue_word(KIND_BIAS, 0, 0, 16'h7FFF, 1'b1);
      queue_word(KIND_WEIGHT, 255, 63, 16'h7FFF, 1'b1);
      queue_word(KIND_BIAS, 0, 63, 16'h8000, 1'b0);
      // stale input entry beyond the active length
      queue_word(KIND_INPUT, 255, 0, 16'h5A5A, 1'b0);
      // positive then negative saturation
      queue_word(KIND_INPUT, 0, 0, 16'h8000, 1'b1);
      queue_word(KIND_WEIGHT, 0, 0, 16'h7FFF, 1'b0);
      queue_word(KIND_BIAS, 0, 0, 16'h8000, 1'b0);
      queue_word(KIND_INPUT, 0, 63, 16'h8000, 1'b1);
      // rounding of exact halves, both signs
      queue_word(KIND_WEIGHT, 0, 0, 16'h0080, 1'b0);
      queue_word(KIND_BIAS, 0, 0, 16'h0000, 1'b0);
      queue_word(KIND_INPUT, 0, 0, 16'h0001, 1'b1);
      queue_word(KIND_INPUT, 0, 0, 16'hFFFF, 1'b1);
      queue_word(KIND_INPUT, 0, 0, 16'hFFFE, 1'b1);
      // final element on a row outside the window still starts a run
      queue_word(KIND_INPUT, 255, 0, 16'h0001, 1'b1);
      drain();

      // longer input vector on a single column
      write_reg(CSR_INPUT_LENGTH, 9'd16);
      write_reg(CSR_OUTPUT_LENGTH, 9'd1);
      fill_unwritten();
      queue_word(KIND_INPUT, $urandom_range(0, 255), 0, pick_value(), 1'b1);
      drain();

      // wider output from a masked write, with a long response hold while the next run waits
      write_reg(CSR_INPUT_LENGTH, 9'd1);
      write_reg(CSR_OUTPUT_LENGTH, 9'h08C);
      long_hold_armed = 1'b1;
      fill_unwritten();
      queue_word(KIND_INPUT, 0, 0, pick_value(), 1'b1);
      queue_word(KIND_INPUT, 0, 0, pick_value(), 1'b1);
      drain();

      // random frames over several small sizes; the tail runs without idling
      base = real_words;
      while (real_words - base < RANDOM_WORDS) begin
         quiet = (real_words - base >= RANDOM_WORDS * 3 / 4);
         write_reg(CSR_INPUT_LENGTH, CSR_W'($urandom_range(1, 6)));
         write_reg(CSR_OUTPUT_LENGTH, CSR_W'($urandom_range(1, 4)));
         repeat ($urandom_range(2, 4)) random_frame();
         drain();
      end

      if (fail_count == 0 && expected_columns.size() == 0)
         $display("dense_layer_matvec_bias_unit_test OK");
      else
         $display("dense_layer_matvec_bias_unit_test NOT OK");
      $finish;
   end

endmodule

>>> filelist.f
sv/dlmv_pkg.sv
sv/dlmv_mem_bank.sv
sv/dlmv_mac.sv
sv/dense_layer_matvec_bias_unit.sv
bench/dense_layer_matvec_bias_unit_test.sv
